// ===== hdl/hsa_pkg.sv =====
package hsa_pkg;

  localparam int FFT_SIZE    = 16;
  localparam int HOP_SIZE    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int NUM_BINS    = FFT_SIZE / 2 + 1;

  localparam int TAP_W      = $clog2(FFT_SIZE);
  localparam int BIN_W      = 4;
  localparam int STEP_W     = TAP_W + 1;
  localparam int FRAME_W    = 16;
  localparam int OUT_W      = 24;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = SAMPLE_BITS + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_W;
  localparam int COEF_DEPTH = NUM_BINS * FFT_SIZE;
  localparam int COEF_IDX_W = BIN_W + TAP_W;
  localparam int FRAC_SHIFT = 30;
  localparam int DIST_W     = 5;
  localparam int POS_W      = 6;
  localparam int NL_W       = 4;
  localparam int SEEN_W     = 4;
  localparam int HOP_W      = $clog2(HOP_SIZE);

  localparam logic [SEEN_W-1:0]       SEEN_FRAME0 = SEEN_W'(FFT_SIZE / 2);
  localparam logic [SEEN_W-1:0]       SEEN_MAX    = SEEN_W'(FFT_SIZE / 2 + 1);
  localparam logic [HOP_W-1:0]        HOP_LAST    = HOP_W'(HOP_SIZE - 1);
  localparam logic [BIN_W-1:0]        BIN_LAST    = BIN_W'(NUM_BINS - 1);
  localparam logic [STEP_W-1:0]       STEP_LAST   = STEP_W'(2 * FFT_SIZE - 1);
  localparam logic signed [DIST_W-1:0] DIST_FRAME0 = -DIST_W'(1);
  localparam logic signed [DIST_W-1:0] DIST_HOP    = DIST_W'(0);
  localparam logic [NL_W-1:0]         NL_BASE     = NL_W'(FFT_SIZE / 2);

  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

  localparam longint COS_Q30 [FFT_SIZE] = '{
    64'sd1073741824, 64'sd992008094, 64'sd759250125, 64'sd410903207,
    64'sd0, -64'sd410903207, -64'sd759250125, -64'sd992008094,
    -64'sd1073741824, -64'sd992008094, -64'sd759250125, -64'sd410903207,
    64'sd0, 64'sd410903207, 64'sd759250125, 64'sd992008094
  };

  typedef logic [COEF_DEPTH-1:0][COEF_W-1:0] coef_tab_t;

  // windowed cosine / negated sine coefficients, Q.30, index bin * FFT_SIZE + tap
  function automatic coef_tab_t build_coef(input bit imag);
    coef_tab_t tab;
    longint    w;
    longint    c;
    longint    t;
    tab = '0;
    for (int f = 0; f < NUM_BINS; f++) begin
      for (int j = 0; j < FFT_SIZE; j++) begin
        w = COS_Q30[0] - COS_Q30[j];
        if (imag) begin
          c = COS_Q30[(f * j + FFT_SIZE - FFT_SIZE / 4) & (FFT_SIZE - 1)];
        end else begin
          c = COS_Q30[(f * j) & (FFT_SIZE - 1)];
        end
        t = (c * w + (64'sd1 <<< FRAC_SHIFT)) >>> (FRAC_SHIFT + 1);
        if (imag) begin
          t = -t;
        end
        tab[f * FFT_SIZE + j] = t[COEF_W-1:0];
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_RE = build_coef(1'b0);
  localparam coef_tab_t COEF_IM = build_coef(1'b1);

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [BIN_W-1:0]   bin_number;
    logic               run_last;
    logic               signal_done;
  } tag_t;

  typedef struct packed {
    logic                     push;
    logic                     issue;
    logic                     sel;
    logic                     first;
    logic                     last;
    logic [TAP_W-1:0]         tap;
    logic signed [DIST_W-1:0] lag;
    logic                     left_ok;
    logic [NL_W-1:0]          nl;
    tag_t                     tag;
  } cmd_t;

  typedef struct packed {
    logic res_pending;
  } stat_t;

endpackage

// ===== hdl/hsa_in_if.sv =====
interface hsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hsa_pkg::SAMPLE_BITS-1:0] sample;
  logic                                 stream_end;

  modport source (output valid, output sample, output stream_end, input ready);
  modport sink (input valid, input sample, input stream_end, output ready);
endinterface

// ===== hdl/hsa_out_if.sv =====
interface hsa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [hsa_pkg::FRAME_W-1:0]           frame_number;
  logic [hsa_pkg::BIN_W-1:0]             bin_number;
  logic signed [hsa_pkg::OUT_W-1:0]      real_part;
  logic signed [hsa_pkg::OUT_W-1:0]      imag_part;
  logic                                  run_last;
  logic                                  signal_done;

  modport source (output valid, output frame_number, output bin_number, output real_part,
                  output imag_part, output run_last, output signal_done, input ready);
  modport sink (input valid, input frame_number, input bin_number, input real_part,
                input imag_part, input run_last, input signal_done, output ready);
endinterface

// ===== hdl/hsa_ctrl.sv =====
module hsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stream_end,
  output logic           in_ready,
  input  hsa_pkg::stat_t stat,
  output hsa_pkg::cmd_t  cmd
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;
  typedef enum logic [1:0] {SLOT_HOP, SLOT_FLUSH_A, SLOT_FLUSH_B} slot_t;

  state_t                            state_r, state_nxt;
  slot_t                             slot_r, slot_nxt;
  logic [hsa_pkg::BIN_W-1:0]         bin_r, bin_nxt;
  logic [hsa_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [hsa_pkg::SEEN_W-1:0]        seen_r, seen_nxt;
  logic [hsa_pkg::HOP_W-1:0]         hop_r, hop_nxt;
  logic [hsa_pkg::FRAME_W-1:0]       frames_r, frames_nxt;
  logic                              head_done_r, head_done_nxt;
  logic                              flush_en_r, flush_en_nxt;
  logic                              end_r, end_nxt;
  logic signed [hsa_pkg::DIST_W-1:0] hop_dist_r, hop_dist_nxt;
  logic signed [hsa_pkg::DIST_W-1:0] flush_dist_r, flush_dist_nxt;
  logic                              left_ok_r, left_ok_nxt;
  logic [hsa_pkg::NL_W-1:0]          nl_r, nl_nxt;

  logic accept;
  logic issue;
  logic hop_go;
  logic flush_go;
  logic slot_final;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state_r == ST_RUN) &&
                    !((step_r == hsa_pkg::STEP_LAST) && stat.res_pending);
  assign hop_go   = (seen_r == hsa_pkg::SEEN_FRAME0) ||
                    ((seen_r >= hsa_pkg::SEEN_MAX) && (hop_r == hsa_pkg::HOP_LAST));
  assign flush_go = in_stream_end && (seen_r >= hsa_pkg::SEEN_FRAME0);
  assign slot_final = (slot_r == SLOT_FLUSH_B) || ((slot_r == SLOT_HOP) && !flush_en_r);

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    bin_nxt        = bin_r;
    step_nxt       = step_r;
    seen_nxt       = seen_r;
    hop_nxt        = hop_r;
    frames_nxt     = frames_r;
    head_done_nxt  = head_done_r;
    flush_en_nxt   = flush_en_r;
    end_nxt        = end_r;
    hop_dist_nxt   = hop_dist_r;
    flush_dist_nxt = flush_dist_r;
    left_ok_nxt    = left_ok_r;
    nl_nxt         = nl_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hop_dist_nxt   = (seen_r == hsa_pkg::SEEN_FRAME0) ? hsa_pkg::DIST_FRAME0
                                                            : hsa_pkg::DIST_HOP;
          flush_dist_nxt = (hop_r == hsa_pkg::HOP_LAST)
                           ? hsa_pkg::DIST_W'(hsa_pkg::HOP_SIZE)
                           : hsa_pkg::DIST_W'(hsa_pkg::HOP_LAST - hop_r);
          left_ok_nxt    = !head_done_r;
          nl_nxt         = hsa_pkg::NL_BASE + hsa_pkg::NL_W'(hop_r);
          flush_en_nxt   = flush_go;
          end_nxt        = in_stream_end;
          slot_nxt       = hop_go ? SLOT_HOP : SLOT_FLUSH_A;
          bin_nxt        = '0;
          step_nxt       = '0;
          if (hop_go || flush_go) begin
            state_nxt = ST_RUN;
          end
          if (in_stream_end) begin
            seen_nxt      = '0;
            hop_nxt       = '0;
            head_done_nxt = 1'b0;
            if (!(hop_go || flush_go)) begin
              frames_nxt = '0;
            end
          end else begin
            if (seen_r < hsa_pkg::SEEN_MAX) begin
              seen_nxt = seen_r + 1'b1;
            end
            hop_nxt = hop_r + 1'b1;
            if (hop_go && (seen_r >= hsa_pkg::SEEN_MAX)) begin
              head_done_nxt = 1'b1;
            end
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (step_r == hsa_pkg::STEP_LAST) begin
            step_nxt = '0;
            if (bin_r == hsa_pkg::BIN_LAST) begin
              bin_nxt    = '0;
              frames_nxt = frames_r + 1'b1;
              if ((slot_r == SLOT_HOP) && flush_en_r) begin
                slot_nxt = SLOT_FLUSH_A;
              end else if (slot_r == SLOT_FLUSH_A) begin
                slot_nxt = SLOT_FLUSH_B;
              end else begin
                state_nxt = ST_IDLE;
                if (end_r) begin
                  frames_nxt = '0;
                end
              end
            end else begin
              bin_nxt = bin_r + 1'b1;
            end
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd                  = '0;
    cmd.push             = accept;
    cmd.issue            = issue;
    cmd.sel              = step_r[0];
    cmd.tap              = step_r[hsa_pkg::STEP_W-1:1];
    cmd.first            = (step_r[hsa_pkg::STEP_W-1:1] == '0);
    cmd.last             = (step_r == hsa_pkg::STEP_LAST);
    cmd.left_ok          = left_ok_r;
    cmd.nl               = nl_r;
    cmd.tag.frame_number = frames_r;
    cmd.tag.bin_number   = bin_r;
    cmd.tag.run_last     = (bin_r == hsa_pkg::BIN_LAST) && slot_final;
    cmd.tag.signal_done  = (bin_r == hsa_pkg::BIN_LAST) && (slot_r == SLOT_FLUSH_B);
    case (slot_r)
      SLOT_HOP:     cmd.lag = hop_dist_r;
      SLOT_FLUSH_A: cmd.lag = flush_dist_r;
      SLOT_FLUSH_B: cmd.lag = flush_dist_r + hsa_pkg::DIST_W'(hsa_pkg::HOP_SIZE);
      default:      cmd.lag = hop_dist_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= SLOT_HOP;
      bin_r        <= '0;
      step_r       <= '0;
      seen_r       <= '0;
      hop_r        <= '0;
      frames_r     <= '0;
      head_done_r  <= 1'b0;
      flush_en_r   <= 1'b0;
      end_r        <= 1'b0;
      hop_dist_r   <= '0;
      flush_dist_r <= '0;
      left_ok_r    <= 1'b0;
      nl_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      bin_r        <= bin_nxt;
      step_r       <= step_nxt;
      seen_r       <= seen_nxt;
      hop_r        <= hop_nxt;
      frames_r     <= frames_nxt;
      head_done_r  <= head_done_nxt;
      flush_en_r   <= flush_en_nxt;
      end_r        <= end_nxt;
      hop_dist_r   <= hop_dist_nxt;
      flush_dist_r <= flush_dist_nxt;
      left_ok_r    <= left_ok_nxt;
      nl_r         <= nl_nxt;
    end
  end

  // the closing op of a bin only goes out once the result path is empty
  a_last_needs_free_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.last) |-> !stat.res_pending)
    else $error("bin closed while a result is still pending");

  a_end_restarts_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_stream_end) |=> ((seen_r == '0) && (hop_r == '0) && !head_done_r))
    else $error("stream counters not cleared after the final sample");

endmodule

// ===== hdl/hsa_datapath.sv =====
module hsa_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hsa_pkg::cmd_t                        cmd,
  input  logic signed [hsa_pkg::SAMPLE_BITS-1:0] in_sample,
  output hsa_pkg::stat_t                       stat,
  hsa_out_if.source                            out_chan
);

  logic signed [hsa_pkg::SAMPLE_BITS-1:0] hist_r [hsa_pkg::FFT_SIZE];

  logic signed [hsa_pkg::POS_W-1:0]      pos_raw;
  logic signed [hsa_pkg::POS_W-1:0]      pos_abs;
  logic signed [hsa_pkg::POS_W-1:0]      pos_refl;
  logic signed [hsa_pkg::POS_W-1:0]      nl_ext;
  logic [hsa_pkg::TAP_W-1:0]             rd_idx;
  logic [hsa_pkg::COEF_IDX_W-1:0]        coef_idx;
  logic signed [hsa_pkg::COEF_W-1:0]     coef_sel;

  logic                                  v1_r, sel1_r, first1_r, last1_r;
  logic signed [hsa_pkg::SAMPLE_BITS-1:0] op_s_r;
  logic signed [hsa_pkg::COEF_W-1:0]     op_c_r;
  hsa_pkg::tag_t                         tag1_r;

  logic                                  v2_r, sel2_r, first2_r, last2_r;
  logic signed [hsa_pkg::PROD_W-1:0]     prod_r;
  hsa_pkg::tag_t                         tag2_r;

  logic signed [hsa_pkg::ACC_W-1:0]      prod_ext;
  logic signed [hsa_pkg::ACC_W-1:0]      acc_re_r, acc_im_r;
  logic                                  fin_r;
  hsa_pkg::tag_t                         tagf_r;

  logic                                  out_valid_r;
  hsa_pkg::tag_t                         out_tag_r;
  logic signed [hsa_pkg::OUT_W-1:0]      out_re_r, out_im_r;

  function automatic logic signed [hsa_pkg::OUT_W-1:0] round_sat(
    input logic signed [hsa_pkg::ACC_W-1:0] a
  );
    logic signed [hsa_pkg::ACC_W-1:0] r;
    r = (a + (hsa_pkg::ACC_W'(1) <<< (hsa_pkg::FRAC_SHIFT - 1))) >>> hsa_pkg::FRAC_SHIFT;
    if (r > hsa_pkg::OUT_MAX) begin
      return hsa_pkg::OUT_W'(hsa_pkg::OUT_MAX);
    end else if (r < hsa_pkg::OUT_MIN) begin
      return hsa_pkg::OUT_W'(hsa_pkg::OUT_MIN);
    end
    return r[hsa_pkg::OUT_W-1:0];
  endfunction

  // padded position of this tap, mirrored at either end of the stream
  always_comb begin
    pos_raw = hsa_pkg::POS_W'(hsa_pkg::FFT_SIZE - 1) - hsa_pkg::POS_W'(cmd.lag)
              - hsa_pkg::POS_W'(cmd.tap);
    pos_abs = (pos_raw < 0) ? -pos_raw : pos_raw;
    nl_ext  = $signed(hsa_pkg::POS_W'(cmd.nl));
    if (cmd.left_ok && (pos_abs > nl_ext)) begin
      pos_refl = (nl_ext <<< 1) - pos_abs;
    end else begin
      pos_refl = pos_abs;
    end
    if (pos_refl < 0) begin
      pos_refl = '0;
    end
    rd_idx = pos_refl[hsa_pkg::TAP_W-1:0];
  end

  assign coef_idx = {cmd.tag.bin_number, cmd.tap};
  assign coef_sel = cmd.sel ? $signed(hsa_pkg::COEF_IM[coef_idx])
                            : $signed(hsa_pkg::COEF_RE[coef_idx]);
  assign prod_ext = hsa_pkg::ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_r[0] <= in_sample;
      for (int i = 1; i < hsa_pkg::FFT_SIZE; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r  <= cmd.issue;
      v2_r  <= v1_r;
      fin_r <= v2_r && last2_r;
      if (fin_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_s_r   <= hist_r[rd_idx];
    op_c_r   <= coef_sel;
    sel1_r   <= cmd.sel;
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    tag1_r   <= cmd.tag;

    prod_r   <= op_s_r * op_c_r;
    sel2_r   <= sel1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    tag2_r   <= tag1_r;

    if (v2_r) begin
      if (sel2_r) begin
        acc_im_r <= (first2_r ? '0 : acc_im_r) + prod_ext;
      end else begin
        acc_re_r <= (first2_r ? '0 : acc_re_r) + prod_ext;
      end
      tagf_r <= tag2_r;
    end

    if (fin_r) begin
      out_re_r  <= round_sat(acc_re_r);
      out_im_r  <= round_sat(acc_im_r);
      out_tag_r <= tagf_r;
    end
  end

  assign stat.res_pending = (v1_r && last1_r) || (v2_r && last2_r) || fin_r || out_valid_r;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_number = out_tag_r.frame_number;
  assign out_chan.bin_number   = out_tag_r.bin_number;
  assign out_chan.real_part    = out_re_r;
  assign out_chan.imag_part    = out_im_r;
  assign out_chan.run_last     = out_tag_r.run_last;
  assign out_chan.signal_done  = out_tag_r.signal_done;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> !out_valid_r)
    else $error("finished bin would overwrite an untaken result");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tag_r.signal_done) |-> out_tag_r.run_last)
    else $error("final bin of the stream not marked as last of its sample");

  a_no_shift_during_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !cmd.issue)
    else $error("history shifted while taps are being read");

endmodule

// ===== hdl/hann_stft_analyzer.sv =====
// bins of a frame are computed one after another through the operand, product, accumulator
// and output registers (one shared 16x32 multiplier, cosine and sine term per tap)
// a sample that closes no frame leaves the block idle and ready for the next; one that
// closes a frame holds off further samples until every bin of that frame has issued, and the
// final sample closes up to three frames; a bin whose result is not taken holds off the next one
// reset: synchronous active-low rst_n clears stream counters and the pipeline valids;
// sample history is not cleared
module hann_stft_analyzer (
  input logic       clk,
  input logic       rst_n,
  hsa_in_if.sink    in_chan,
  hsa_out_if.source out_chan
);

  hsa_pkg::cmd_t  cmd;
  hsa_pkg::stat_t stat;
  logic           in_ready;

  hsa_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_stream_end (in_chan.stream_end),
    .in_ready      (in_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  assign in_chan.ready = in_ready;

  hsa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_chan.sample),
    .stat      (stat),
    .out_chan  (out_chan)
  );

endmodule
